// ===== rtl/core/cpp_pkg.sv =====
package cpp_pkg;
    localparam int IDX_BITS = 10;
    localparam int SQ_BITS  = 63;
    localparam int Q16_BITS = 48;
    localparam int FIELD_BITS = 31;
    typedef logic [63:0] t_square;
endpackage

// ===== rtl/core/cpp_sqrt.sv =====
module cpp_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cpp_pkg::t_square    i_value,
    output logic                o_done,
    output logic [47:0]         o_root
);
    import cpp_pkg::*;

    logic [5:0]  r_step, n_step;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    t_square     r_val, n_val;
    logic [47:0] r_q, n_q;
    logic [49:0] r_rem, n_rem;
    logic [49:0] w_rem_sh;
    logic [49:0] w_trial;

    assign w_rem_sh = {r_rem[47:0], r_val[63:62]};
    assign w_trial  = {r_q, 2'b01};

    always_comb begin
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        n_val  = r_val;
        n_q    = r_q;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = 6'd0;
            n_val  = i_value;
            n_q    = '0;
            n_rem  = '0;
        end else if (r_busy) begin
            n_val = {r_val[61:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                n_rem = w_rem_sh - w_trial;
                n_q   = {r_q[46:0], 1'b1};
            end else begin
                n_rem = w_rem_sh;
                n_q   = {r_q[46:0], 1'b0};
            end
            n_step = r_step + 6'd1;
            if (r_step == 6'd47) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_val <= n_val;
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_root = r_q;
endmodule

// ===== rtl/core/closest_pair_of_points.sv =====
// Closest pair of points. Points load one per request in a single cycle each
// and are numbered by arrival. The request marked last starts a search over
// all stored pairs with one shared distance unit: pair (i,j) steps through a
// read of point j, the difference, the square and the compare, and each new
// first point i adds a read of point i before its pairs. The square root
// follows the search, then the result. The pair time is set by the single
// read port of the point memory followed by the registered difference and
// square stages. Points beyond MAX_POINTS are dropped and flagged. The block
// takes no request while a search runs or a result waits.
module closest_pair_of_points #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [30:0]     i_x_coord,
    input  logic signed [30:0]     i_y_coord,
    input  logic                   i_last_point,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_pair_found,
    output logic [9:0]             o_first_index,
    output logic [9:0]             o_second_index,
    output logic [62:0]            o_squared_distance,
    output logic [47:0]            o_distance_q16,
    output logic                   o_overflow
);
    import cpp_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam logic [2:0] S_LOAD = 3'd0, S_RDI = 3'd1, S_RDJ = 3'd2,
                           S_MUL = 3'd3, S_CMP = 3'd4, S_ROOT = 3'd5, S_OUT = 3'd6,
                           S_SQR = 3'd7;

    logic [2*COORD_BITS-1:0] r_mem [MAX_POINTS];
    logic [2*COORD_BITS-1:0] r_rd;
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_i, n_i, r_j, n_j;
    logic [AW-1:0] r_addr;
    logic signed [COORD_BITS-1:0] r_xi, r_yi;
    logic [COORD_BITS:0] r_dx, r_dy;
    logic [63:0]   r_sx, r_sy;
    t_square       r_best, n_best;
    logic [AW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic          r_drop, n_drop;
    logic          w_accept, w_done;
    logic [47:0]   w_root;
    logic signed [COORD_BITS:0] w_ex, w_ey;
    t_square       w_sq;

    assign o_ready  = (r_state == S_LOAD);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (w_accept && r_count < CW'(MAX_POINTS))
            r_mem[r_count[AW-1:0]] <= {i_x_coord[COORD_BITS-1:0], i_y_coord[COORD_BITS-1:0]};
        r_rd <= r_mem[r_addr];
    end

    always_comb begin
        r_addr = r_i;
        if (r_state == S_RDJ) r_addr = r_j;
    end

    assign w_ex = {r_xi[COORD_BITS-1], r_xi}
                - {r_rd[2*COORD_BITS-1], r_rd[2*COORD_BITS-1:COORD_BITS]};
    assign w_ey = {r_yi[COORD_BITS-1], r_yi}
                - {r_rd[COORD_BITS-1], r_rd[COORD_BITS-1:0]};
    assign w_sq = r_sx + r_sy;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_i = r_i;
        n_j = r_j;
        n_best = r_best;
        n_lo = r_lo;
        n_hi = r_hi;
        n_drop = r_drop;
        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (r_count < CW'(MAX_POINTS)) n_count = r_count + CW'(1);
                    else n_drop = 1'b1;
                    if (i_last_point) begin
                        n_i = '0;
                        n_j = AW'(1);
                        if (r_count >= CW'(1)) n_state = S_RDI;
                        else n_state = S_OUT;
                    end
                end
            end
            S_RDI: n_state = S_RDJ;
            S_RDJ: n_state = S_MUL;
            S_MUL: n_state = S_SQR;
            S_SQR: n_state = S_CMP;
            S_CMP: begin
                if (w_sq < r_best) begin
                    n_best = w_sq;
                    n_lo = r_i;
                    n_hi = r_j;
                end
                if (CW'(r_j) + CW'(1) < r_count) begin
                    n_j = r_j + AW'(1);
                    n_state = S_RDJ;
                end else if (CW'(r_i) + CW'(2) < r_count) begin
                    n_i = r_i + AW'(1);
                    n_j = r_i + AW'(2);
                    n_state = S_RDI;
                end else begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: if (w_done) n_state = S_OUT;
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_LOAD;
                    n_count = '0;
                    n_best = '1;
                    n_lo = '0;
                    n_hi = '0;
                    n_drop = 1'b0;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    logic r_root_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_best <= '1;
            r_lo <= '0;
            r_hi <= '0;
            r_drop <= 1'b0;
            r_root_go <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_best <= n_best;
            r_lo <= n_lo;
            r_hi <= n_hi;
            r_drop <= n_drop;
            r_root_go <= (r_state == S_CMP) && (n_state == S_ROOT);
        end
        r_i <= n_i;
        r_j <= n_j;
        if (r_state == S_RDJ) begin
            r_xi <= r_rd[2*COORD_BITS-1:COORD_BITS];
            r_yi <= r_rd[COORD_BITS-1:0];
        end
        if (r_state == S_MUL) begin
            r_dx <= w_ex[COORD_BITS] ? (COORD_BITS+1)'(0) - w_ex : w_ex;
            r_dy <= w_ey[COORD_BITS] ? (COORD_BITS+1)'(0) - w_ey : w_ey;
        end
    end

    // Point i is read at RDI or at the compare before a new j, point j at RDJ,
    // and read data is valid in the next cycle. Squares are ready at CMP.
    always_ff @(posedge i_clk) begin
        r_sx <= 64'(r_dx) * 64'(r_dx);
        r_sy <= 64'(r_dy) * 64'(r_dy);
    end

    cpp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_root_go),
        .i_value (r_best),
        .o_done  (w_done),
        .o_root  (w_root)
    );

    logic w_found;
    assign w_found = r_count >= CW'(2);
    assign o_valid = (r_state == S_OUT);
    assign o_pair_found = w_found;
    assign o_first_index  = w_found ? IDX_BITS'(r_lo) : '0;
    assign o_second_index = w_found ? IDX_BITS'(r_hi) : '0;
    assign o_squared_distance = w_found ? r_best[SQ_BITS-1:0] : '0;
    assign o_distance_q16 = w_found ? w_root : '0;
    assign o_overflow = r_drop;
endmodule

// ===== tb/tb_closest_pair_of_points.sv =====
`timescale 1ns / 100ps

module tb_closest_pair_of_points;
    import cpp_pkg::*;

    localparam int CAPACITY = 1024;
    localparam int STALL_LIMIT = 10000000;
    localparam logic signed [30:0] C_MIN = 31'sh4000_0000;
    localparam logic signed [30:0] C_MAX = 31'sh3FFF_FFFF;

    typedef struct packed {
        logic                found;
        logic [IDX_BITS-1:0] lo;
        logic [IDX_BITS-1:0] hi;
        logic [SQ_BITS-1:0]  sq;
        logic [Q16_BITS-1:0] q16;
        logic                ovf;
    } t_pair_result;

    typedef struct packed {
        logic signed [30:0] x;
        logic signed [30:0] y;
        logic               last;
        logic               typed;
        t_pair_result       res;
    } t_dir_row;

    localparam int N_DIR = 14;
    localparam t_dir_row DIR_TABLE [N_DIR] = '{
        '{31'sd7, -31'sd3, 1'b1, 1'b1, '{1'b0, 10'd0, 10'd0, 63'd0, 48'd0, 1'b0}},
        '{31'sd0, 31'sd0, 1'b0, 1'b0, '0},
        '{31'sd3, 31'sd4, 1'b1, 1'b1, '{1'b1, 10'd0, 10'd1, 63'd25, 48'd327680, 1'b0}},
        '{C_MIN, C_MIN, 1'b0, 1'b0, '0},
        '{C_MAX, C_MAX, 1'b1, 1'b0, '0},
        '{31'sd0, 31'sd0, 1'b0, 1'b0, '0},
        '{31'sd1, 31'sd0, 1'b0, 1'b0, '0},
        '{31'sd2, 31'sd0, 1'b1, 1'b1, '{1'b1, 10'd0, 10'd1, 63'd1, 48'd65536, 1'b0}},
        '{31'sd5, 31'sd5, 1'b0, 1'b0, '0},
        '{31'sd7, 31'sd7, 1'b0, 1'b0, '0},
        '{31'sd5, 31'sd5, 1'b1, 1'b1, '{1'b1, 10'd0, 10'd2, 63'd0, 48'd0, 1'b0}},
        '{C_MIN, C_MAX, 1'b0, 1'b0, '0},
        '{C_MAX, C_MIN, 1'b0, 1'b0, '0},
        '{-31'sd1, -31'sd1, 1'b1, 1'b0, '0}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic signed [30:0]        i_x_coord;
    logic signed [30:0]        i_y_coord;
    logic                      i_last_point;
    logic                      o_valid;
    logic                      i_ready;
    logic                      o_pair_found;
    logic [9:0]                o_first_index;
    logic [9:0]                o_second_index;
    logic [62:0]               o_squared_distance;
    logic [47:0]               o_distance_q16;
    logic                      o_overflow;

    closest_pair_of_points dut (.*);

    longint       stored_x [CAPACITY];
    longint       stored_y [CAPACITY];
    int           stored_count;
    logic         points_dropped;
    t_pair_result pending_pairs [$];
    int           mismatches;
    int           points_sent;
    int           sets_sent;
    int           pairs_checked;
    int           tx_idle_pct;
    int           rx_stall_pct;
    int           rx_hold;
    int           quiet_cycles;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [Q16_BITS-1:0] root_q16(t_square v);
        logic [127:0]        rad;
        logic [127:0]        trial;
        logic [Q16_BITS-1:0] q;
        rad = {64'd0, v} << 32;
        q = '0;
        for (int b = Q16_BITS - 1; b >= 0; b--) begin
            trial = {80'd0, q | (48'd1 << b)};
            if (trial * trial <= rad) begin
                q = q | (48'd1 << b);
            end
        end
        return q;
    endfunction

    function automatic t_pair_result closest_pair_search();
        t_pair_result r;
        t_square      best;
        t_square      sq;
        longint       dx;
        longint       dy;
        int           lo;
        int           hi;
        best = '1;
        lo = 0;
        hi = 0;
        for (int i = 0; i < stored_count; i++) begin
            for (int j = i + 1; j < stored_count; j++) begin
                dx = stored_x[i] - stored_x[j];
                dy = stored_y[i] - stored_y[j];
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                sq = t_square'(dx * dx) + t_square'(dy * dy);
                if (sq < best) begin
                    best = sq;
                    lo = i;
                    hi = j;
                end
            end
        end
        r = '0;
        r.ovf = points_dropped;
        if (stored_count >= 2) begin
            r.found = 1'b1;
            r.lo = lo[IDX_BITS-1:0];
            r.hi = hi[IDX_BITS-1:0];
            r.sq = best[SQ_BITS-1:0];
            r.q16 = root_q16(best);
        end
        return r;
    endfunction

    task automatic accept_point(logic signed [30:0] x, logic signed [30:0] y, logic last,
                                logic typed, t_pair_result typed_res);
        t_pair_result r;
        if (stored_count < CAPACITY) begin
            stored_x[stored_count] = longint'(x);
            stored_y[stored_count] = longint'(y);
            stored_count++;
        end else begin
            points_dropped = 1'b1;
        end
        if (last) begin
            r = closest_pair_search();
            pending_pairs = {pending_pairs, (typed ? typed_res : r)};
            stored_count = 0;
            points_dropped = 1'b0;
            sets_sent++;
        end
    endtask

    task automatic send_point(logic signed [30:0] x, logic signed [30:0] y, logic last,
                              logic typed = 1'b0, t_pair_result typed_res = '0);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_x_coord = x;
        i_y_coord = y;
        i_last_point = last;
        do @(posedge i_clk); while (!o_ready);
        points_sent++;
        accept_point(x, y, last, typed, typed_res);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic logic signed [30:0] pick_coord(int mode, logic signed [30:0] base);
        int          off;
        logic [31:0] raw;
        off = int'($urandom_range(16)) - 8;
        raw = $urandom;
        case (mode)
            0: return raw[30:0];
            1: return off[30:0];
            2: return raw[0] ? C_MIN + 31'($urandom_range(7)) : C_MAX - 31'($urandom_range(7));
            default: return base + off[30:0];
        endcase
    endfunction

    task automatic send_random_sets(int n_points);
        int                 target;
        int                 size;
        int                 mode;
        logic signed [30:0] base;
        logic [31:0]        raw;
        target = points_sent + n_points;
        while (points_sent < target) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
            mode = $urandom_range(3);
            raw = $urandom;
            base = raw[30:0];
            for (int k = 0; k < size; k++) begin
                send_point(pick_coord(mode, base), pick_coord(mode, base), k == size - 1);
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s at %0t: got 0x%0h, expected 0x%0h", what, $time, got, want);
        mismatches++;
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_ready = 1'b0;
            rx_hold--;
        end else begin
            i_ready = $urandom_range(99) >= rx_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        t_pair_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pairs.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_first_index), 64'd0);
            end else begin
                want = pending_pairs.pop_front();
                pairs_checked++;
                if (o_pair_found !== want.found)
                    report_mismatch("pair_found", 64'(o_pair_found), 64'(want.found));
                if (o_first_index !== want.lo)
                    report_mismatch("first_index", 64'(o_first_index), 64'(want.lo));
                if (o_second_index !== want.hi)
                    report_mismatch("second_index", 64'(o_second_index), 64'(want.hi));
                if (o_squared_distance !== want.sq)
                    report_mismatch("squared_distance", 64'(o_squared_distance), 64'(want.sq));
                if (o_distance_q16 !== want.q16)
                    report_mismatch("distance_q16", 64'(o_distance_q16), 64'(want.q16));
                if (o_overflow !== want.ovf)
                    report_mismatch("overflow", 64'(o_overflow), 64'(want.ovf));
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** closest_pair_of_points: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] raw_x;
        logic [31:0] raw_y;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_x_coord = '0;
        i_y_coord = '0;
        i_last_point = 1'b0;
        stored_count = 0;
        points_dropped = 1'b0;
        mismatches = 0;
        points_sent = 0;
        sets_sent = 0;
        pairs_checked = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            send_point(DIR_TABLE[r].x, DIR_TABLE[r].y, DIR_TABLE[r].last,
                       DIR_TABLE[r].typed, DIR_TABLE[r].res);
        end

        // A set two points past capacity; the dropped final point still starts the search.
        for (int k = 0; k < CAPACITY + 2; k++) begin
            raw_x = $urandom;
            raw_y = $urandom;
            send_point(raw_x[30:0], raw_y[30:0], k == CAPACITY + 1);
        end

        send_random_sets(22);
        tx_idle_pct = 56;
        send_random_sets(22);
        tx_idle_pct = 0;
        rx_stall_pct = 56;
        send_random_sets(22);
        tx_idle_pct = 35;
        rx_stall_pct = 35;
        send_random_sets(22);

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        @(posedge i_clk);
        rx_hold = 400;
        @(negedge i_clk);
        send_random_sets(10);
        wait (pending_pairs.size() == 0);
        repeat (40) @(negedge i_clk);
        send_random_sets(10);

        i_valid = 1'b0;
        wait (pending_pairs.size() == 0);
        repeat (60) @(posedge i_clk);
        if (pending_pairs.size() != 0) begin
            report_mismatch("results never delivered", 64'(pending_pairs.size()), 64'd0);
        end
        $display("Sent %0d points in %0d sets, including one set past capacity.",
                 points_sent, sets_sent);
        $display("Checked %0d results under idle, stall and long back-pressure phases.",
                 pairs_checked);
        if (mismatches == 0) begin
            $display("** closest_pair_of_points: PASSED **");
        end else begin
            $display("** closest_pair_of_points: FAILED **");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/cpp_pkg.sv
rtl/core/cpp_sqrt.sv
rtl/core/closest_pair_of_points.sv
tb/tb_closest_pair_of_points.sv
